@@ hw/rtl/jpsp_pkg.sv @@
// Shared types and constants for the joypad serial port pair.
// Used by jpsp_pad_mem, jpsp_core and joypad_serial_port_pair; no dependencies.
`default_nettype none

package jpsp_pkg;

   localparam int unsigned NUM_PADS_DEF    = 8;
   localparam int unsigned BUTTON_BITS_DEF = 16;

   localparam int unsigned KIND_W  = 3;
   localparam int unsigned SLOT_W  = 3;
   localparam int unsigned BIND_W  = 4;
   localparam int unsigned IDX_W   = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned CSR_A_W = 2;

   localparam logic [KIND_W-1:0] KIND_LATCH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_AUTO  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SOFT  = 3'd4;

   localparam logic [CSR_A_W-1:0] CSR_PORT0_BINDING = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_PORT1_BINDING = 2'd1;

   localparam logic [BIND_W-1:0] BIND_PORT0_RESET = 4'd0;
   localparam logic [BIND_W-1:0] BIND_NONE        = 4'd8;

   localparam logic [IDX_W-1:0]  IDX_MAX       = 8'hFF;
   localparam logic [BYTE_W-1:0] PORT1_ID_BITS = 8'h1C;
   localparam logic [BYTE_W-1:0] OPEN_BUS_MASK = 8'hFC;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              latch_level;
      logic              port_select;
      logic [BYTE_W-1:0] open_bus;
      logic [SLOT_W-1:0] pad_slot;
      logic [WORD_W-1:0] button_word;
   } req_type;

   typedef logic [1:0][BIND_W-1:0] bind_pair_type;

endpackage : jpsp_pkg

`default_nettype wire

@@ hw/rtl/jpsp_pad_mem.sv @@
// Pad button store: one write port, two registered read ports with write bypass.
// Depends on jpsp_pkg; entries read as zero until first written.
`default_nettype none

module jpsp_pad_mem
   import jpsp_pkg::*;
#(
   parameter int unsigned NUM_PADS    = NUM_PADS_DEF,
   parameter int unsigned BUTTON_BITS = BUTTON_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [SLOT_W-1:0]              wr_slot,
   input  wire logic [BUTTON_BITS-1:0]         wr_data,
   input  wire bind_pair_type                  rd_bind,
   output logic      [1:0][BUTTON_BITS-1:0]    rd_data
);

   localparam int unsigned AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

   logic [BUTTON_BITS-1:0]      mem [NUM_PADS];
   logic [NUM_PADS-1:0]         valid_ff;
   logic [NUM_PADS-1:0]         valid_in;
   logic [1:0][BUTTON_BITS-1:0] rd_data_ff;
   logic [1:0][BUTTON_BITS-1:0] rd_data_in;
   logic [AW-1:0]               wr_addr;

   assign wr_addr = AW'(wr_slot);
   assign rd_data = rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         rd_data_in[p] = '0;
         if (rd_bind[p] < BIND_W'(NUM_PADS)) begin
            if (wr_en && (AW'(rd_bind[p]) == wr_addr)) begin
               rd_data_in[p] = wr_data;
            end else if (valid_ff[AW'(rd_bind[p])]) begin
               rd_data_in[p] = mem[AW'(rd_bind[p])];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= rd_data_in;
   end

endmodule : jpsp_pad_mem

`default_nettype wire

@@ hw/rtl/jpsp_core.sv @@
// Port state (latch, bindings, read indices) and the result register.
// Depends on jpsp_pkg; takes button words from jpsp_pad_mem.
`default_nettype none

module jpsp_core
   import jpsp_pkg::*;
#(
   parameter int unsigned NUM_PADS    = NUM_PADS_DEF,
   parameter int unsigned BUTTON_BITS = BUTTON_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire req_type                     req,
   input  wire bind_pair_type               pend_bind,
   input  wire logic [1:0][BUTTON_BITS-1:0] pad_word,
   output bind_pair_type                    bind_next,
   output logic                             mem_wr_en,
   output logic      [SLOT_W-1:0]           mem_wr_slot,
   output logic      [BUTTON_BITS-1:0]      mem_wr_data,
   output logic                             rsp_valid,
   output logic      [BYTE_W-1:0]           rsp_read_byte,
   output logic      [WORD_W-1:0]           rsp_auto_word_port0,
   output logic      [WORD_W-1:0]           rsp_auto_word_port1
);

   localparam int unsigned BPW = $clog2(BUTTON_BITS);

   logic                   latch_ff, latch_in;
   bind_pair_type          bind_ff, bind_in;
   logic [1:0][IDX_W-1:0]  idx_ff, idx_in;
   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic [1:0][WORD_W-1:0] word_ff, word_in;

   logic                   port;
   logic                   bound;
   logic [BYTE_W-1:0]      bits;
   logic [IDX_W-1:0]       idx_cur;
   logic [BPW-1:0]         bit_pos;

   assign port    = req.port_select;
   assign bound   = bind_ff[port] < BIND_W'(NUM_PADS);
   assign bits    = (req.open_bus & OPEN_BUS_MASK) | (port ? PORT1_ID_BITS : '0);
   assign idx_cur = idx_ff[port];
   assign bit_pos = BPW'(BUTTON_BITS - 1) - idx_cur[BPW-1:0];

   assign mem_wr_en   = req_valid && (req.kind == KIND_SET)
                        && ({1'b0, req.pad_slot} < BIND_W'(NUM_PADS));
   assign mem_wr_slot = req.pad_slot;
   assign mem_wr_data = req.button_word[BUTTON_BITS-1:0];

   assign bind_next = bind_in;

   always_comb begin
      latch_in = latch_ff;
      bind_in  = bind_ff;
      idx_in   = idx_ff;
      byte_in  = '0;
      word_in  = '0;
      if (req_valid) begin
         unique case (req.kind)
            KIND_LATCH: begin
               if (req.latch_level && !latch_ff) begin
                  idx_in = '0;
               end else if (!req.latch_level && latch_ff) begin
                  bind_in = pend_bind;
               end
               latch_in = req.latch_level;
            end
            KIND_READ: begin
               byte_in = bits;
               if (!bound) begin
                  if (!latch_ff && (idx_cur != IDX_MAX)) begin
                     idx_in[port] = idx_cur + 1'b1;
                  end
               end else if (latch_ff) begin
                  byte_in[0] = pad_word[port][BUTTON_BITS-1];
               end else begin
                  if (idx_cur != IDX_MAX) begin
                     idx_in[port] = idx_cur + 1'b1;
                  end
                  if (idx_cur >= IDX_W'(BUTTON_BITS)) begin
                     byte_in[0] = 1'b1;
                  end else begin
                     byte_in[0] = pad_word[port][bit_pos];
                  end
               end
            end
            KIND_AUTO: begin
               if (!latch_ff) begin
                  idx_in = '0;
               end
               latch_in = 1'b0;
               bind_in  = pend_bind;
               for (int n = 0; n < 2; n++) begin
                  if (pend_bind[n] < BIND_W'(NUM_PADS)) begin
                     idx_in[n]  = IDX_W'(BUTTON_BITS);
                     word_in[n] = WORD_W'(pad_word[n]);
                  end
               end
            end
            KIND_SOFT: begin
               idx_in   = '0;
               latch_in = 1'b0;
               bind_in  = pend_bind;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff     <= 1'b0;
         bind_ff[0]   <= BIND_PORT0_RESET;
         bind_ff[1]   <= BIND_NONE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         latch_ff     <= latch_in;
         bind_ff      <= bind_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      word_ff <= word_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_byte       = byte_ff;
   assign rsp_auto_word_port0 = word_ff[0];
   assign rsp_auto_word_port1 = word_ff[1];

endmodule : jpsp_core

`default_nettype wire

@@ hw/rtl/joypad_serial_port_pair.sv @@
// Top level of the joypad serial port pair: request register, binding registers.
// Depends on jpsp_pkg, jpsp_pad_mem and jpsp_core.
//
// Usage:
//   Request channel: drive req_* and raise start; a request is taken at each
//   rising edge with start high and busy low. busy is always low, so one
//   request can be issued every cycle.
//   Response channel: each request gives exactly one response, shown on rsp_*
//   with rsp_valid high for one cycle; the request register and then the
//   response register in jpsp_core lie between a request and its response.
//   Responses come out in request order. The receiver cannot stall them.
//   Configuration: csr_index 0 writes the port 0 binding, 1 the port 1
//   binding; other indexes are ignored. csr_ready is always high. Write only
//   while no response is pending.
//   Throughput: one request per cycle, set by the single pass from the request
//   register through the port logic into the response register.
//   Reset: synchronous; bindings return to port 0 on slot 0 and port 1
//   unplugged, latch and read indexes clear, all pad words read as zero.
`default_nettype none

module joypad_serial_port_pair
   import jpsp_pkg::*;
#(
   parameter int unsigned NUM_PADS    = NUM_PADS_DEF,
   parameter int unsigned BUTTON_BITS = BUTTON_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic                req_latch_level,
   input  wire logic                req_port_select,
   input  wire logic [BYTE_W-1:0]   req_open_bus,
   input  wire logic [SLOT_W-1:0]   req_pad_slot,
   input  wire logic [WORD_W-1:0]   req_button_word,
   output logic                     rsp_valid,
   output logic      [BYTE_W-1:0]   rsp_read_byte,
   output logic      [WORD_W-1:0]   rsp_auto_word_port0,
   output logic      [WORD_W-1:0]   rsp_auto_word_port1,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CSR_A_W-1:0]  csr_index,
   input  wire logic [BIND_W-1:0]   csr_data
);

   logic                        req_valid_ff;
   req_type                     req_ff;
   req_type                     req_in;
   bind_pair_type               pend_ff;
   bind_pair_type               bind_next;
   bind_pair_type               rd_bind;
   logic [1:0][BUTTON_BITS-1:0] pad_word;
   logic                        mem_wr_en;
   logic [SLOT_W-1:0]           mem_wr_slot;
   logic [BUTTON_BITS-1:0]      mem_wr_data;
   logic                        accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign req_in.kind        = req_kind;
   assign req_in.latch_level = req_latch_level;
   assign req_in.port_select = req_port_select;
   assign req_in.open_bus    = req_open_bus;
   assign req_in.pad_slot    = req_pad_slot;
   assign req_in.button_word = req_button_word;

   // auto read fetches with the bindings it is about to copy in
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         rd_bind[p] = (req_kind == KIND_AUTO) ? pend_ff[p] : bind_next[p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         pend_ff[0]   <= BIND_PORT0_RESET;
         pend_ff[1]   <= BIND_NONE;
      end else begin
         req_valid_ff <= accept;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PORT0_BINDING) begin
               pend_ff[0] <= csr_data;
            end else if (csr_index == CSR_PORT1_BINDING) begin
               pend_ff[1] <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   jpsp_pad_mem #(
      .NUM_PADS    (NUM_PADS),
      .BUTTON_BITS (BUTTON_BITS)
   ) u_pad_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_slot (mem_wr_slot),
      .wr_data (mem_wr_data),
      .rd_bind (rd_bind),
      .rd_data (pad_word)
   );

   jpsp_core #(
      .NUM_PADS    (NUM_PADS),
      .BUTTON_BITS (BUTTON_BITS)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid_ff),
      .req                 (req_ff),
      .pend_bind           (pend_ff),
      .pad_word            (pad_word),
      .bind_next           (bind_next),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_slot         (mem_wr_slot),
      .mem_wr_data         (mem_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_auto_word_port0 (rsp_auto_word_port0),
      .rsp_auto_word_port1 (rsp_auto_word_port1)
   );

endmodule : joypad_serial_port_pair

`default_nettype wire
